### design/rv32i_instruction_executor_top_assert.svh
// assertion macros used by the port-level checker
`ifndef RV32I_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH
`define RV32I_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH
// condition in the same cycle implies consequence in the same cycle
`define RV32IE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rv32ie assertion failed");
// condition implies consequence in the following cycle
`define RV32IE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rv32ie assertion failed");
`endif

### design/rv32ie_pkg.sv
// shared types and constants of the rv32i instruction executor
`timescale 1ns / 1ps
`default_nettype none
package rv32ie_pkg;
	// data memory geometry, a power of two of bytes
	localparam int DATA_BYTES = 4096;
	localparam int DMEM_AW    = $clog2(DATA_BYTES);
	localparam int ROW_AW     = DMEM_AW - 2;
	localparam int ROWS       = DATA_BYTES / 4;

	// major opcodes
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [31:0] ECALL_WORD  = 32'h0000_0073;
	localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
	localparam logic [6:0]  F7_BASE     = 7'h00;
	localparam logic [6:0]  F7_ALT      = 7'h20;
	localparam logic [2:0]  F3_CSRRS    = 3'd2;

	// access sizes
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	typedef enum logic [2:0] {
		HALT_NONE    = 3'd0,
		HALT_ECALL   = 3'd1,
		HALT_EBREAK  = 3'd2,
		HALT_ILLEGAL = 3'd3,
		HALT_CSR     = 3'd4
	} halt_t;

	// data memory request, one per cycle
	typedef struct packed {
		logic        en;
		logic        we;
		logic [31:0] addr;
		logic [1:0]  size;
		logic [31:0] data;
	} mem_req_t;
endpackage
`default_nettype wire

### design/rv32ie_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module rv32ie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### design/rv32ie_dmem.sv
// byte-banked data memory with wrapping unaligned access
`timescale 1ns / 1ps
`default_nettype none
module rv32ie_dmem (
	input  logic                clk,
	input  rv32ie_pkg::mem_req_t req,
	output logic [31:0]         rdata
);
	import rv32ie_pkg::*;

	logic [1:0]        a0;
	logic [1:0]        a0_q;
	logic [ROW_AW-1:0] row0;
	logic [7:0]        bank_q [4];

	assign a0   = req.addr[1:0];
	assign row0 = req.addr[DMEM_AW-1:2];

	// remember the byte offset for reassembly
	always_ff @(posedge clk) begin
		if (req.en && !req.we) begin
			a0_q <= a0;
		end
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [1:0]        k;
		logic              wrap;
		logic [ROW_AW-1:0] row;
		logic              lane_we;

		// byte k of the access lands in this bank
		always_comb begin
			k    = 2'(b) - a0;
			wrap = 2'(b) < a0;
			row  = row0 + {{(ROW_AW-1){1'b0}}, wrap};
			case (req.size)
				SIZE_BYTE: lane_we = (k == 2'd0);
				SIZE_HALF: lane_we = (k <= 2'd1);
				default:   lane_we = 1'b1;
			endcase
		end

		rv32ie_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
			.clk   (clk),
			.we    (req.en && req.we && lane_we),
			.waddr (row),
			.wdata (req.data[8*k +: 8]),
			.re    (req.en && !req.we),
			.raddr (row),
			.rdata (bank_q[b])
		);
	end

	// put bytes back in access order
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rdata[8*k +: 8] = bank_q[2'(a0_q + 2'(k))];
		end
	end
endmodule
`default_nettype wire

### design/rv32i_instruction_executor_top.sv
// rv32i executor: register file ram, execute stage, data memory, result register
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | instruction
// cfg     | input     | cfg_valid / cfg_ready | hart_id
// out     | output    | out_valid / out_ready | instruction_pc .. executed_count
//
// one instruction per cycle while out is not stalled and no clearing pass runs; a result is
// registered through register read, execute with memory access, load alignment and writeback
// register file updates are forwarded and memory writes land before any later
// read, so no bubbles occur
// after reset a clearing pass over the DATA_BYTES/4 data memory rows zeroes the data memory
// and the register file; in_ready stays low during it, cfg is always taken
// a stall on out freezes the whole pipeline
`timescale 1ns / 1ps
`default_nettype none
module rv32i_instruction_executor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] hart_id,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instruction,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] instruction_pc,
	output logic [31:0] next_pc,
	output logic        dest_write,
	output logic [4:0]  dest_reg,
	output logic [31:0] dest_value,
	output logic        store_write,
	output logic [31:0] store_address,
	output logic [31:0] store_data,
	output logic [1:0]  store_size,
	output logic [2:0]  halt_cause,
	output logic [31:0] executed_count
);
	import rv32ie_pkg::*;

	logic              advance;
	logic              accept;
	logic              clr_q;
	logic [ROW_AW-1:0] clr_cnt_q;
	logic [31:0]       hart_id_q;

	// architectural state outside the memories
	logic [31:0] pc_q;
	logic        halted_q;
	halt_t       reason_q;
	logic [31:0] count_q;

	// execute stage
	logic        valid_s1;
	logic [31:0] insn_s1;
	logic [31:0] rf1_q, rf2_q;

	// writeback stage
	logic        valid_s2;
	logic [31:0] pc_s2, npc_s2, alu_s2, st_addr_s2, st_data_s2, count_s2;
	logic        wr_s2, load_s2, st_s2;
	logic [4:0]  rd_s2;
	logic [2:0]  lf3_s2;
	logic [1:0]  st_size_s2;
	halt_t       cause_s2;

	// last register file write
	logic        wb_valid_q;
	logic [4:0]  wb_rd_q;
	logic [31:0] wb_val_q;

	logic [31:0] ld_word, ld_val, val_s2;
	logic        rf_we;
	logic [4:0]  rf_waddr;
	logic [31:0] rf_wdata;
	mem_req_t    mreq;

	// execute results
	logic [31:0] rs1v, rs2v, imm_i, imm_s, imm_j, imm_b, opb, x_npc, x_val, x_addr;
	logic        x_wr, x_load, x_st, take, live;
	logic [1:0]  x_size;
	logic [31:0] x_st_data;
	halt_t       x_cause;
	logic [6:0]  opc, f7;
	logic [2:0]  f3;
	logic [4:0]  rs1, rs2, rd;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid || out_ready;
	assign in_ready  = advance && !clr_q;
	assign accept    = in_valid && in_ready;

	// hart id register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hart_id_q <= '0;
		end else if (cfg_valid) begin
			hart_id_q <= hart_id;
		end
	end

	// clearing pass over data memory rows and register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ROW_AW'(ROWS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// register file write port, shared by clearing and writeback
	always_comb begin
		if (clr_q) begin
			rf_we    = (clr_cnt_q[ROW_AW-1:5] == '0);
			rf_waddr = clr_cnt_q[4:0];
			rf_wdata = '0;
		end else begin
			rf_we    = advance && valid_s2 && wr_s2;
			rf_waddr = rd_s2;
			rf_wdata = val_s2;
		end
	end

	rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(advance), .raddr(instruction[19:15]), .rdata(rf1_q)
	);

	rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(advance), .raddr(instruction[24:20]), .rdata(rf2_q)
	);

	// instruction register of the execute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			insn_s1 <= instruction;
		end
	end

	// decode, operand forwarding and execute
	always_comb begin
		opc   = insn_s1[6:0];
		rd    = insn_s1[11:7];
		f3    = insn_s1[14:12];
		rs1   = insn_s1[19:15];
		rs2   = insn_s1[24:20];
		f7    = insn_s1[31:25];
		imm_i = {{20{insn_s1[31]}}, insn_s1[31:20]};
		imm_s = {{20{insn_s1[31]}}, insn_s1[31:25], insn_s1[11:7]};
		imm_j = {{11{insn_s1[31]}}, insn_s1[31], insn_s1[19:12], insn_s1[20],
			insn_s1[30:21], 1'b0};
		imm_b = {{19{insn_s1[31]}}, insn_s1[31], insn_s1[7], insn_s1[30:25],
			insn_s1[11:8], 1'b0};
		live  = valid_s1 && !halted_q;

		if (valid_s2 && wr_s2 && rd_s2 == rs1) begin
			rs1v = val_s2;
		end else if (wb_valid_q && wb_rd_q == rs1) begin
			rs1v = wb_val_q;
		end else begin
			rs1v = rf1_q;
		end
		if (valid_s2 && wr_s2 && rd_s2 == rs2) begin
			rs2v = val_s2;
		end else if (wb_valid_q && wb_rd_q == rs2) begin
			rs2v = wb_val_q;
		end else begin
			rs2v = rf2_q;
		end

		x_npc     = pc_q + 32'd4;
		x_wr      = 1'b0;
		x_val     = '0;
		x_load    = 1'b0;
		x_st      = 1'b0;
		x_size    = SIZE_BYTE;
		x_st_data = '0;
		x_addr    = rs1v + imm_i;
		x_cause   = HALT_NONE;
		take      = 1'b0;
		opb       = (opc == OPC_OP) ? rs2v : imm_i;

		if (insn_s1 == ECALL_WORD) begin
			x_cause = HALT_ECALL;
			x_npc   = pc_q;
		end else if (insn_s1 == EBREAK_WORD) begin
			x_cause = HALT_EBREAK;
			x_npc   = pc_q;
		end else begin
			case (opc)
				OPC_LUI: begin
					x_wr  = 1'b1;
					x_val = {insn_s1[31:12], 12'h000};
				end
				OPC_AUIPC: begin
					x_wr  = 1'b1;
					x_val = pc_q + {insn_s1[31:12], 12'h000};
				end
				OPC_JAL: begin
					x_wr  = 1'b1;
					x_val = pc_q + 32'd4;
					x_npc = pc_q + imm_j;
				end
				OPC_JALR: begin
					x_wr  = 1'b1;
					x_val = pc_q + 32'd4;
					x_npc = x_addr & 32'hffff_fffe;
				end
				OPC_BRANCH: begin
					case (f3)
						3'd0:    take = (rs1v == rs2v);
						3'd1:    take = (rs1v != rs2v);
						3'd4:    take = ($signed(rs1v) < $signed(rs2v));
						3'd5:    take = ($signed(rs1v) >= $signed(rs2v));
						3'd6:    take = (rs1v < rs2v);
						3'd7:    take = (rs1v >= rs2v);
						default: take = 1'b0;
					endcase
					if (take) begin
						x_npc = pc_q + imm_b;
					end
				end
				OPC_LOAD: begin
					x_wr   = 1'b1;
					x_load = 1'b1;
				end
				OPC_STORE: begin
					x_addr = rs1v + imm_s;
					if (f3 <= 3'd2) begin
						x_st   = 1'b1;
						x_size = f3[1:0];
						case (f3[1:0])
							SIZE_BYTE: x_st_data = {24'h0, rs2v[7:0]};
							SIZE_HALF: x_st_data = {16'h0, rs2v[15:0]};
							default:   x_st_data = rs2v;
						endcase
					end
				end
				OPC_OPIMM, OPC_OP: begin
					x_wr = 1'b1;
					case (f3)
						3'd0: begin
							if (opc == OPC_OPIMM || f7 == F7_BASE) begin
								x_val = rs1v + opb;
							end else if (f7 == F7_ALT) begin
								x_val = rs1v - opb;
							end else begin
								x_val = '0;
							end
						end
						3'd1: x_val = rs1v << opb[4:0];
						3'd2: x_val = {31'h0, $signed(rs1v) < $signed(opb)};
						3'd3: x_val = {31'h0, rs1v < opb};
						3'd4: x_val = rs1v ^ opb;
						3'd5: begin
							if (f7 == F7_BASE) begin
								x_val = rs1v >> opb[4:0];
							end else if (f7 == F7_ALT) begin
								x_val = 32'($signed(rs1v) >>> opb[4:0]);
							end else begin
								x_val = '0;
							end
						end
						3'd6:    x_val = rs1v | opb;
						default: x_val = rs1v & opb;
					endcase
				end
				OPC_SYSTEM: begin
					if (f3 == F3_CSRRS) begin
						x_wr  = 1'b1;
						x_val = hart_id_q;
					end else begin
						x_cause = HALT_CSR;
					end
				end
				default: begin
					x_cause = HALT_ILLEGAL;
					x_npc   = pc_q;
				end
			endcase
		end

		if (rd == 5'd0) begin
			x_wr = 1'b0;
		end
	end

	// data memory request: clearing sweep or execute access
	always_comb begin
		if (clr_q) begin
			mreq.en   = 1'b1;
			mreq.we   = 1'b1;
			mreq.addr = 32'({clr_cnt_q, 2'b00});
			mreq.size = SIZE_WORD;
			mreq.data = '0;
		end else begin
			mreq.en   = advance && live && (x_load || x_st);
			mreq.we   = x_st;
			mreq.addr = x_addr;
			mreq.size = x_size;
			mreq.data = x_st_data;
		end
	end

	rv32ie_dmem u_dmem (
		.clk   (clk),
		.req   (mreq),
		.rdata (ld_word)
	);

	// architectural state update at execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			halted_q <= 1'b0;
			reason_q <= HALT_NONE;
			count_q  <= '0;
		end else if (advance && live) begin
			pc_q    <= x_npc;
			count_q <= count_q + 32'd1;
			if (x_cause != HALT_NONE) begin
				halted_q <= 1'b1;
				reason_q <= x_cause;
			end
		end
	end

	// execute to writeback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pc_s2      <= pc_q;
			npc_s2     <= live ? x_npc : pc_q;
			wr_s2      <= live && x_wr;
			rd_s2      <= rd;
			alu_s2     <= x_val;
			load_s2    <= x_load;
			lf3_s2     <= f3;
			st_s2      <= live && x_st;
			st_addr_s2 <= x_addr;
			st_data_s2 <= x_st_data;
			st_size_s2 <= x_size;
			cause_s2   <= live ? x_cause : reason_q;
			count_s2   <= live ? count_q + 32'd1 : count_q;
		end
	end

	// load alignment and extension
	always_comb begin
		case (lf3_s2)
			3'd0:    ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
			3'd1:    ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
			3'd2:    ld_val = ld_word;
			3'd4:    ld_val = {24'h0, ld_word[7:0]};
			3'd5:    ld_val = {16'h0, ld_word[15:0]};
			default: ld_val = '0;
		endcase
		val_s2 = load_s2 ? ld_val : alu_s2;
	end

	// last write kept for the next read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_q <= 1'b0;
			wb_rd_q    <= '0;
			wb_val_q   <= '0;
		end else if (advance && valid_s2 && wr_s2) begin
			wb_valid_q <= 1'b1;
			wb_rd_q    <= rd_s2;
			wb_val_q   <= val_s2;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			instruction_pc <= pc_s2;
			next_pc        <= npc_s2;
			dest_write     <= wr_s2;
			dest_reg       <= wr_s2 ? rd_s2 : 5'd0;
			dest_value     <= wr_s2 ? val_s2 : 32'd0;
			store_write    <= st_s2;
			store_address  <= st_s2 ? st_addr_s2 : 32'd0;
			store_data     <= st_s2 ? st_data_s2 : 32'd0;
			store_size     <= st_s2 ? st_size_s2 : SIZE_BYTE;
			halt_cause     <= cause_s2;
			executed_count <= count_s2;
		end
	end
endmodule
`default_nettype wire

### design/rv32ie_checker.sv
// port-level checker for the rv32i executor, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "rv32i_instruction_executor_top_assert.svh"
module rv32ie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        dest_write,
	input logic [4:0]  dest_reg,
	input logic [31:0] dest_value,
	input logic        store_write,
	input logic [31:0] store_address,
	input logic [31:0] store_data,
	input logic [1:0]  store_size
);
	// a stalled result stays
	`RV32IE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// x0 is never reported as written
	`RV32IE_ASSERT_IMP(a_no_x0, out_valid && dest_write, dest_reg != 5'd0)
	// no destination write means zero destination fields
	`RV32IE_ASSERT_IMP(a_dest_zero, out_valid && !dest_write, dest_value == 32'd0 && dest_reg == 5'd0)
	// no store means zero store fields
	`RV32IE_ASSERT_IMP(a_store_zero, out_valid && !store_write, store_address == 32'd0 && store_data == 32'd0 && store_size == 2'd0)
endmodule

bind rv32i_instruction_executor_top rv32ie_checker u_rv32ie_checker (.*);
`default_nettype wire
